// ===== rtl/ppt_pkg.sv =====
package ppt_pkg;

    // Field widths of the stream items
    localparam int NODE_W   = 11;
    localparam int PARENT_W = 10;
    localparam int KIDS_W   = 10;
    localparam int DEPTH_W  = 5;

    // Packed port widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    // Default sizing
    localparam int PPT_STACK_DEPTH = 32;
    localparam int PPT_MAX_NODES   = 1024;

    // Request kinds carried on s_tuser
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // Datapath operations issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE   = 4'd1;
    localparam logic [OP_W-1:0] OP_START     = 4'd2;
    localparam logic [OP_W-1:0] OP_OVERFLOW  = 4'd3;
    localparam logic [OP_W-1:0] OP_PUSH      = 4'd4;
    localparam logic [OP_W-1:0] OP_STEP      = 4'd5;
    localparam logic [OP_W-1:0] OP_POP       = 4'd6;
    localparam logic [OP_W-1:0] OP_LOAD_TOP  = 4'd7;
    localparam logic [OP_W-1:0] OP_DEC       = 4'd8;
    localparam logic [OP_W-1:0] OP_EMIT      = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } ppt_cmd_t;

    typedef struct packed {
        logic start_req;  // captured request is a start
        logic fin;        // walk has ended
        logic kids_nz;    // captured child count is nonzero
        logic top_full;   // a push would run past the last stack level
        logic top_nz;     // top entry is not the root
        logic pend_zero;  // top entry has no pending children
        logic out_free;   // output register can take a result
    } ppt_status_t;

endpackage

// ===== rtl/ppt_ctrl.sv =====
module ppt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ppt_pkg::ppt_status_t status,
    output ppt_pkg::ppt_cmd_t    cmd
);
    import ppt_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_POP_CHK  = 3'd2;
    localparam logic [2:0] ST_POP_LOAD = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // no transfer is taken while reset is held
    assign s_tready = aresetn && (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath command
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (status.start_req) begin
                    cmd.op     = OP_START;
                    state_next = ST_EMIT;
                end else if (status.fin) begin
                    state_next = ST_EMIT;
                end else if (status.kids_nz && status.top_full) begin
                    cmd.op     = OP_OVERFLOW;
                    state_next = ST_EMIT;
                end else if (status.kids_nz) begin
                    cmd.op     = OP_PUSH;
                    state_next = ST_EMIT;
                end else begin
                    cmd.op     = OP_STEP;
                    state_next = ST_POP_CHK;
                end
            end
            ST_POP_CHK: begin
                // drop finished entries one at a time, the root stays
                if (status.top_nz && status.pend_zero) begin
                    cmd.op     = OP_POP;
                    state_next = ST_POP_LOAD;
                end else begin
                    cmd.op     = OP_DEC;
                    state_next = ST_EMIT;
                end
            end
            ST_POP_LOAD: begin
                cmd.op     = OP_LOAD_TOP;
                state_next = ST_POP_CHK;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An accepted item is always worked on in the next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not start execution");

    // A result is handed over only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |-> (status.out_free && state_reg == ST_EMIT))
        else $error("result loaded while output register busy");

endmodule

// ===== rtl/ppt_datapath.sv =====
module ppt_datapath #(
    parameter int STACK_DEPTH = ppt_pkg::PPT_STACK_DEPTH,
    parameter int MAX_NODES   = ppt_pkg::PPT_MAX_NODES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tuser,
    input  logic [ppt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           cfg_valid,
    input  logic [ppt_pkg::NODE_W-1:0]     cfg_data,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [ppt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [ppt_pkg::M_TUSER_W-1:0]  m_tuser,
    input  ppt_pkg::ppt_cmd_t              cmd,
    output ppt_pkg::ppt_status_t           status
);
    import ppt_pkg::*;

    localparam int TOP_W   = $clog2(STACK_DEPTH);
    localparam int ENTRY_W = PARENT_W + NODE_W;
    localparam logic [TOP_W-1:0] TOP_LAST = TOP_W'(STACK_DEPTH - 1);

    // Stack entries below the top: ancestor index and pending children
    logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [NODE_W-1:0]   node_count_reg;
    logic                req_reg;
    logic [KIDS_W-1:0]   kids_reg;
    logic [TOP_W-1:0]    top_reg;
    logic [PARENT_W-1:0] top_idx_reg;   // top entry held in registers
    logic [NODE_W-1:0]   top_pend_reg;
    logic [NODE_W-1:0]   cur_reg;
    logic                fin_reg;
    logic                ovf_reg;
    logic                out_valid_reg;
    logic [NODE_W-1:0]   out_node_reg;
    logic [PARENT_W-1:0] out_parent_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic                out_root_reg;
    logic                out_fin_reg;
    logic                out_ovf_reg;

    logic [NODE_W-1:0] cur_inc;
    logic              cur_end;
    logic              top_nz;
    logic              out_free;

    assign cur_inc  = cur_reg + NODE_W'(1);
    assign cur_end  = (cur_inc >= node_count_reg);
    assign top_nz   = (top_reg != '0);
    assign out_free = !out_valid_reg || m_tready;

    // Status to the controller
    always_comb begin
        status.start_req = (req_reg == REQ_START);
        status.fin       = fin_reg;
        status.kids_nz   = (kids_reg != '0);
        status.top_full  = (top_reg == TOP_LAST);
        status.top_nz    = top_nz;
        status.pend_zero = (top_pend_reg == '0);
        status.out_free  = out_free;
    end

    // Stack memory: write the old top on push, registered read on pop
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_PUSH) begin
            stack_mem[top_reg] <= {top_idx_reg, top_pend_reg};
        end
        if (cmd.op == OP_POP) begin
            rd_data_reg <= stack_mem[top_reg - TOP_W'(1)];
        end
    end

    // Captured input item
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CAPTURE) begin
            req_reg  <= s_tuser;
            kids_reg <= s_tdata[KIDS_W-1:0];
        end
    end

    // Walk state, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_W'(1);
            top_reg        <= '0;
            top_idx_reg    <= '0;
            top_pend_reg   <= '0;
            cur_reg        <= '0;
            fin_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            // node count saturates at the largest tree
            if (cfg_valid) begin
                if (32'(cfg_data) > 32'(MAX_NODES)) begin
                    node_count_reg <= NODE_W'(MAX_NODES);
                end else begin
                    node_count_reg <= cfg_data;
                end
            end
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_START: begin
                    top_reg      <= '0;
                    cur_reg      <= '0;
                    top_idx_reg  <= '0;
                    top_pend_reg <= node_count_reg;
                    ovf_reg      <= 1'b0;
                    fin_reg      <= (node_count_reg == '0);
                end
                OP_OVERFLOW: begin
                    cur_reg <= node_count_reg;
                    fin_reg <= 1'b1;
                    ovf_reg <= 1'b1;
                end
                OP_PUSH, OP_STEP: begin
                    if (cmd.op == OP_PUSH) begin
                        // new entry already gives up the child that follows
                        top_reg      <= top_reg + TOP_W'(1);
                        top_idx_reg  <= cur_reg[PARENT_W-1:0];
                        top_pend_reg <= NODE_W'(kids_reg) - NODE_W'(1);
                    end
                    if (cur_end) begin
                        cur_reg <= node_count_reg;
                        fin_reg <= 1'b1;
                    end else begin
                        cur_reg <= cur_inc;
                    end
                end
                OP_POP: begin
                    top_reg <= top_reg - TOP_W'(1);
                end
                OP_LOAD_TOP: begin
                    top_idx_reg  <= rd_data_reg[ENTRY_W-1:NODE_W];
                    top_pend_reg <= rd_data_reg[NODE_W-1:0];
                end
                OP_DEC: begin
                    if (top_pend_reg != '0) begin
                        top_pend_reg <= top_pend_reg - NODE_W'(1);
                    end
                end
                OP_EMIT: begin
                    out_valid_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            out_node_reg <= cur_reg;
            out_fin_reg  <= fin_reg;
            out_ovf_reg  <= ovf_reg;
            if (fin_reg) begin
                out_parent_reg <= '0;
                out_root_reg   <= 1'b0;
                out_depth_reg  <= '0;
            end else begin
                out_parent_reg <= top_nz ? top_idx_reg : '0;
                out_root_reg   <= !top_nz;
                out_depth_reg  <= DEPTH_W'(top_reg);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - NODE_W - PARENT_W - DEPTH_W)'(0),
                       out_depth_reg, out_parent_reg, out_node_reg};
    assign m_tuser  = {out_ovf_reg, out_fin_reg, out_root_reg};

    // An aborted walk is always a finished walk
    a_ovf_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> fin_reg)
        else $error("overflow set without finish");

    // Finished results carry no parent
    a_done_parent: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_fin_reg) |->
            (out_parent_reg == '0 && out_depth_reg == '0 && !out_root_reg))
        else $error("finished result carries a parent");

    // Root entry is never popped
    a_no_root_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_POP) |-> top_nz)
        else $error("pop of the root entry");

endmodule

// ===== rtl/preorder_parent_tracker.sv =====
// Preorder parent tracker. Each input transfer is a start (s_tuser = 0) or an
// advance (s_tuser = 1) carrying the current node's child count; each one gives
// exactly one result transfer with the new current node, its parent index, the
// parent's stack level and the done and overflow flags. One item is worked on
// at a time: a start, an advance that pushes or overflows, or any request once
// the walk is done goes from the execute state to the emit state, which loads
// the result register and returns to idle for the next item; an advance that
// pushes nothing first visits the pop check state, which does one stack memory
// read and one top entry reload for each finished ancestor that it pops. A
// result waiting on m_tready holds back only the next item's result, not its
// acceptance. node_count is to be written on the cfg port only while the block
// is idle, which the block does not enforce; values above MAX_NODES saturate.
module preorder_parent_tracker #(
    parameter int STACK_DEPTH = ppt_pkg::PPT_STACK_DEPTH,
    parameter int MAX_NODES   = ppt_pkg::PPT_MAX_NODES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppt_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] child_count
    input  logic                           s_tuser,   // [0] req_type
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ppt_pkg::M_TDATA_W-1:0]  m_tdata,   // [10:0] node_index,
                                                      // [20:11] parent_index,
                                                      // [25:21] depth
    output logic [ppt_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] parent_is_root,
                                                      // [1] done_res, [2] overflow
    // node_count register
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ppt_pkg::NODE_W-1:0]     cfg_data
);
    import ppt_pkg::*;

    ppt_cmd_t    cmd;
    ppt_status_t status;

    // writes are taken whenever reset is released
    assign cfg_ready = aresetn;

    ppt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppt_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_NODES   (MAX_NODES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== verif/ppt_walk_checker.sv =====
// Watches the request, result and node_count channels of the preorder parent
// tracker, predicts the parent report for every accepted request and compares
// each result transfer against the oldest outstanding prediction.
module ppt_walk_checker
    import ppt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [NODE_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   outstanding
);

    typedef struct {
        logic [NODE_W-1:0]   node_index;
        logic [PARENT_W-1:0] parent_index;
        logic                parent_is_root;
        logic [DEPTH_W-1:0]  depth;
        logic                done_res;
        logic                overflow;
    } walk_report_t;

    // Predicted walk state
    logic [NODE_W-1:0]   nodes_cfg;
    logic [PARENT_W-1:0] anc_index   [PPT_STACK_DEPTH];
    logic [NODE_W-1:0]   anc_pending [PPT_STACK_DEPTH];
    int unsigned         top_lvl;
    logic [NODE_W-1:0]   cur_node;
    logic                walk_done;
    logic                walk_ovf;

    walk_report_t walk_reports_q[$];
    int           errs = 0;

    // Report for the current walk position; parent fields read as zero once done
    function automatic walk_report_t report_now();
        walk_report_t r;
        r.node_index = cur_node;
        r.done_res   = walk_done;
        r.overflow   = walk_ovf;
        if (walk_done) begin
            r.parent_index   = '0;
            r.parent_is_root = 1'b0;
            r.depth          = '0;
        end else begin
            r.parent_index   = (top_lvl != 0) ? anc_index[top_lvl] : '0;
            r.parent_is_root = (top_lvl == 0);
            r.depth          = DEPTH_W'(top_lvl);
        end
        return r;
    endfunction

    // Apply one request to the predicted walk and queue the expected report
    function automatic void track_request(logic kind, logic [KIDS_W-1:0] kids);
        logic push_blocked;
        push_blocked = 1'b0;
        if (kind == REQ_START) begin
            top_lvl        = 0;
            cur_node       = '0;
            anc_index[0]   = '0;
            anc_pending[0] = nodes_cfg;
            walk_ovf       = 1'b0;
            walk_done      = (nodes_cfg == 0);
        end else if (!walk_done) begin
            if (kids != 0) begin
                if (top_lvl + 1 >= PPT_STACK_DEPTH) begin
                    // nesting too deep: abort the walk
                    cur_node     = nodes_cfg;
                    walk_done    = 1'b1;
                    walk_ovf     = 1'b1;
                    push_blocked = 1'b1;
                end else begin
                    top_lvl              = top_lvl + 1;
                    anc_index[top_lvl]   = cur_node[PARENT_W-1:0];
                    anc_pending[top_lvl] = NODE_W'(kids);
                end
            end
            if (!push_blocked) begin
                cur_node = cur_node + 1'b1;
                // drop finished ancestors, the root entry stays
                while (top_lvl != 0 && anc_pending[top_lvl] == 0)
                    top_lvl = top_lvl - 1;
                if (anc_pending[top_lvl] != 0)
                    anc_pending[top_lvl] = anc_pending[top_lvl] - 1'b1;
                if (cur_node >= nodes_cfg) begin
                    cur_node  = nodes_cfg;
                    walk_done = 1'b1;
                end
            end
        end
        walk_reports_q.push_back(report_now());
    endfunction

    function automatic void cmp_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        walk_report_t want;
        walk_report_t got;
        if (!aresetn) begin
            nodes_cfg = NODE_W'(1);
            top_lvl   = 0;
            cur_node  = '0;
            walk_done = 1'b0;
            walk_ovf  = 1'b0;
            walk_reports_q.delete();
        end else begin
            // node_count write, saturating at the largest tree
            if (cfg_valid && cfg_ready)
                nodes_cfg = (cfg_data > PPT_MAX_NODES) ? NODE_W'(PPT_MAX_NODES) : cfg_data;

            // result transfer against oldest prediction
            if (m_tvalid && m_tready) begin
                got.node_index     = m_tdata[NODE_W-1:0];
                got.parent_index   = m_tdata[NODE_W +: PARENT_W];
                got.depth          = m_tdata[NODE_W+PARENT_W +: DEPTH_W];
                got.parent_is_root = m_tuser[0];
                got.done_res       = m_tuser[1];
                got.overflow       = m_tuser[2];
                if (walk_reports_q.size() == 0) begin
                    $error("unexpected result transfer: node_index %0d", got.node_index);
                    errs++;
                end else begin
                    want = walk_reports_q.pop_front();
                    cmp_field("node_index", want.node_index, got.node_index);
                    cmp_field("parent_index", want.parent_index, got.parent_index);
                    cmp_field("parent_is_root", want.parent_is_root, got.parent_is_root);
                    cmp_field("depth", want.depth, got.depth);
                    cmp_field("done_res", want.done_res, got.done_res);
                    cmp_field("overflow", want.overflow, got.overflow);
                end
            end

            // request transfer
            if (s_tvalid && s_tready)
                track_request(s_tuser, s_tdata[KIDS_W-1:0]);
        end
        outstanding <= walk_reports_q.size();
        fail_count  <= errs;
    end

endmodule

// ===== verif/tb_preorder_parent_tracker.sv =====
// Drives start/advance requests and node_count writes into the tracker under
// several handshake pressure modes; ppt_walk_checker does the scoring.
module tb_preorder_parent_tracker;
    import ppt_pkg::*;

    localparam int TOTAL_ITEMS = 1900;

    typedef enum int {WALK_TREE, WALK_DEEP, WALK_NOISE} walk_style_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = REQ_START;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [NODE_W-1:0]    cfg_data  = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire                  cfg_ready;
    wire [M_TDATA_W-1:0]  m_tdata;
    wire [M_TUSER_W-1:0]  m_tuser;
    int                   fail_count;
    int                   outstanding;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          sent_count    = 0;
    int unsigned nodes_now     = 1;   // effective node_count, for sizing walks

    preorder_parent_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ppt_walk_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // One request transfer; valid stays high afterwards unless a gap follows
    task automatic send_req(input logic kind, input logic [KIDS_W-1:0] kids);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'(kids);
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Hold off requests until every predicted result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_nodes(input logic [NODE_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        nodes_now = (value > PPT_MAX_NODES) ? PPT_MAX_NODES : value;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
        endcase
    endtask

    function automatic logic [KIDS_W-1:0] pick_kids(walk_style_t style);
        int unsigned r;
        r = $urandom_range(99);
        if (style == WALK_NOISE)
            return KIDS_W'($urandom_range(0, 1023));
        if (style == WALK_DEEP) begin
            // mostly single-child chains to drive the stack deep
            if (r < 93) return KIDS_W'(1);
            if (r < 97) return '0;
            return KIDS_W'($urandom_range(2, 1023));
        end
        if (r < 55) return '0;
        if (r < 88) return KIDS_W'($urandom_range(1, 3));
        if (r < 96) return KIDS_W'($urandom_range(4, 15));
        return KIDS_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [NODE_W-1:0] pick_node_count(int phase);
        case (phase % 8)
            0: return NODE_W'(40);
            1: return NODE_W'(PPT_MAX_NODES);
            2: return NODE_W'($urandom_range(1, 12));
            3: return NODE_W'(33);
            4: return NODE_W'($urandom_range(1025, 2047));
            5: return NODE_W'($urandom_range(1, 64));
            6: return '0;
            default: return NODE_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // A start followed by advances; large trees are walked only partway
    task automatic run_walk(input walk_style_t style);
        int unsigned len;
        if (sent_count >= TOTAL_ITEMS)
            return;
        if (nodes_now > 80)
            len = (style == WALK_DEEP) ? 60 : $urandom_range(20, 80);
        else
            len = nodes_now + $urandom_range(0, 2);
        if ($urandom_range(99) < 15)
            len = $urandom_range(0, len);
        send_req(REQ_START, KIDS_W'($urandom));
        for (int i = 0; i < len && sent_count < TOTAL_ITEMS; i++) begin
            if (style == WALK_NOISE && $urandom_range(99) < 10)
                send_req(REQ_START, KIDS_W'($urandom));
            else
                send_req(REQ_ADVANCE, pick_kids(style));
        end
    endtask

    initial begin
        int          phase;
        int unsigned r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset node_count of one: a single node, then repeated done
        send_req(REQ_START, '0);
        send_req(REQ_ADVANCE, '0);
        send_req(REQ_ADVANCE, '0);

        // Empty tree finishes on start
        write_nodes('0);
        send_req(REQ_START, '0);
        send_req(REQ_ADVANCE, KIDS_W'(1023));

        // Oversized count saturates; child count extremes; restart mid-walk
        write_nodes(NODE_W'(2047));
        send_req(REQ_START, KIDS_W'(1023));
        send_req(REQ_ADVANCE, KIDS_W'(1023));
        send_req(REQ_ADVANCE, KIDS_W'(10'h2AA));
        send_req(REQ_ADVANCE, KIDS_W'(10'h155));
        send_req(REQ_ADVANCE, '0);
        send_req(REQ_START, '0);

        // Finished ancestor popped back to the root
        write_nodes(NODE_W'(3));
        send_req(REQ_START, '0);
        send_req(REQ_ADVANCE, KIDS_W'(1));
        send_req(REQ_ADVANCE, '0);
        send_req(REQ_ADVANCE, '0);

        // Root runs out of pending children after node_count grows mid-walk
        write_nodes(NODE_W'(2));
        send_req(REQ_START, '0);
        send_req(REQ_ADVANCE, '0);
        write_nodes(NODE_W'(6));
        repeat (4) send_req(REQ_ADVANCE, '0);

        // Random walks, one node_count and pressure mode per phase
        phase = 0;
        while (sent_count < TOTAL_ITEMS) begin
            write_nodes(pick_node_count(phase));
            set_idle(phase % 4);
            repeat ($urandom_range(4, 12)) begin
                r = $urandom_range(99);
                if (r < 70)
                    run_walk(WALK_TREE);
                else if (r < 90)
                    run_walk(WALK_DEEP);
                else
                    run_walk(WALK_NOISE);
                if ($urandom_range(99) < 5)
                    drain_results();
            end
            phase++;
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
